FILE: rtl/core/endpoint_health_selector_core_defines.svh
// assertion macros for the port-level checker of the endpoint health selector
`ifndef ENDPOINT_HEALTH_SELECTOR_CORE_DEFINES_SVH
`define ENDPOINT_HEALTH_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define EHS_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define EHS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define EHS_ASSERT_NEXT_ALWAYS(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/ehs_pkg.sv
// shared types, constants and helpers of the endpoint health selector
`default_nettype none
package ehs_pkg;

    localparam int MAX_ENDPOINTS = 16;
    localparam int IDX_W         = $clog2(MAX_ENDPOINTS);
    localparam int CNT_W         = $clog2(MAX_ENDPOINTS + 1);

    localparam int POOL_W     = 5;
    localparam int TPS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = CFG_IDX_W'(1);

    localparam logic [POOL_W-1:0] POOL_RESET = '0;
    localparam logic [TPS_W-1:0]  TPS_RESET  = TPS_W'(1000);

    localparam int LAT_W    = 24;
    localparam int FAIL_W   = 8;
    localparam int TIME_W   = 48;
    localparam int SAMPLE_W = 16;
    localparam int FACTOR_W = 10;
    localparam int SCORE_W  = LAT_W + FACTOR_W;
    localparam int SHIFT_W  = 3;
    localparam int DUR_W    = TPS_W + 6;

    // average update divides by ten through a reciprocal multiply
    localparam int DIV_X_W     = 28;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = DIV_X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP10 = RECIP_W'(429496730);

    localparam logic [LAT_W-1:0]   DEFAULT_LAT = LAT_W'(128000);
    localparam logic [FAIL_W-1:0]  FAIL_MAX    = '1;
    localparam logic [FAIL_W-1:0]  MAX_SHIFT   = FAIL_W'(6);

    localparam logic [1:0] ACT_SELECT  = 2'd0;
    localparam logic [1:0] ACT_SUCCESS = 2'd1;
    localparam logic [1:0] ACT_FAILURE = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SELECT  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_EMPTY   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SUCCESS = OP_W'(2);
    localparam logic [OP_W-1:0] OP_FAILURE = OP_W'(3);
    localparam logic [OP_W-1:0] OP_TICK    = OP_W'(4);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]          action;
        logic [IDX_W-1:0]    endpoint_index;
        logic [SAMPLE_W-1:0] latency_ms;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             pool_empty;
    } out_item_t;

    typedef struct packed {
        logic [POOL_W-1:0] pool_size;
        logic [TPS_W-1:0]  ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    idx;
        logic [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [CNT_W-1:0] active_slots(input logic [POOL_W-1:0] ps);
        logic [CNT_W-1:0] n;
        if (int'(ps) > MAX_ENDPOINTS) begin
            n = CNT_W'(MAX_ENDPOINTS);
        end else begin
            n = CNT_W'(ps);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ehs_queue.sv
// short command queue between the front and the back
`default_nettype none
module ehs_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  ehs_pkg::cmd_t          push_cmd,
    input  wire                    pop,
    output ehs_pkg::cmd_t          pop_cmd,
    output ehs_pkg::queue_status_t status
);
    import ehs_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ehs_front.sv
// input acceptance and classification of items into back-end commands
`default_nettype none
module ehs_front (
    input  wire                    s_valid,
    output logic                   s_ready,
    input  ehs_pkg::in_item_t      s_data,
    input  ehs_pkg::cfg_t          cfg,
    input  ehs_pkg::queue_status_t q_status,
    output logic                   q_push,
    output ehs_pkg::cmd_t          q_cmd
);
    import ehs_pkg::*;

    logic [CNT_W-1:0] n;
    logic             in_pool;
    logic             keep;

    assign n       = active_slots(cfg.pool_size);
    assign in_pool = (CNT_W'(s_data.endpoint_index) < n);

    always_comb begin
        q_cmd.idx    = s_data.endpoint_index;
        q_cmd.sample = s_data.latency_ms;
        unique case (s_data.action)
            ACT_SELECT: begin
                q_cmd.op = (n == '0) ? OP_EMPTY : OP_SELECT;
                keep     = 1'b1;
            end
            ACT_SUCCESS: begin
                q_cmd.op = OP_SUCCESS;
                keep     = in_pool;
            end
            ACT_FAILURE: begin
                q_cmd.op = OP_FAILURE;
                keep     = in_pool;
            end
            default: begin
                q_cmd.op = OP_TICK;
                keep     = 1'b1;
            end
        endcase
    end

    // reports outside the pool are dropped after the transfer
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready && keep;

endmodule
`default_nettype wire

FILE: rtl/core/ehs_back.sv
// slot health records, selection scan and report updates
`default_nettype none
module ehs_back (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  ehs_pkg::cfg_t          cfg,
    input  ehs_pkg::queue_status_t q_status,
    input  ehs_pkg::cmd_t          q_cmd,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire                    m_ready,
    output ehs_pkg::out_item_t     m_data
);
    import ehs_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE    = ST_W'(0);
    localparam logic [ST_W-1:0] ST_SCAN    = ST_W'(1);
    localparam logic [ST_W-1:0] ST_SUCC    = ST_W'(2);
    localparam logic [ST_W-1:0] ST_SUCC_WR = ST_W'(3);
    localparam logic [ST_W-1:0] ST_FAIL    = ST_W'(4);
    localparam logic [ST_W-1:0] ST_RESULT  = ST_W'(5);

    // slot records; a slot without its valid bit reads as all zero
    logic [MAX_ENDPOINTS-1:0] valid_reg;
    logic [LAT_W-1:0]         lat_avg_reg [MAX_ENDPOINTS];
    logic [FAIL_W-1:0]        fail_reg    [MAX_ENDPOINTS];
    logic [TIME_W-1:0]        qend_reg    [MAX_ENDPOINTS];

    logic [ST_W-1:0]   state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic               s1_quar_reg, s1_quar_next;
    logic [SCORE_W-1:0] s1_score_reg, s1_score_next;
    logic [TIME_W-1:0]  s1_qend_reg, s1_qend_next;

    logic               found_reg, found_next;
    logic [SCORE_W-1:0] low_score_reg, low_score_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               fb_any_reg, fb_any_next;
    logic [TIME_W-1:0]  fb_qend_reg, fb_qend_next;
    logic [IDX_W-1:0]   fb_idx_reg, fb_idx_next;
    logic               res_empty_reg, res_empty_next;
    logic [LAT_W-1:0]   new_lat_reg, new_lat_next;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic [CNT_W-1:0]    n;
    logic [IDX_W-1:0]    rd_addr;
    logic [LAT_W-1:0]    rd_lat;
    logic [FAIL_W-1:0]   rd_fail;
    logic [TIME_W-1:0]   rd_qend;
    logic [LAT_W-1:0]    eff_lat;
    logic [FACTOR_W-1:0] factor;
    logic [DIV_X_W-1:0]  div_sum, div_x;
    logic [PROD_W-1:0]   div_prod;
    logic [FAIL_W-1:0]   fail_inc;
    logic [SHIFT_W-1:0]  shift;
    logic [DUR_W-1:0]    dur;
    logic                fb_take, best_take, out_free;

    logic               wr_en;
    logic [LAT_W-1:0]   wr_lat;
    logic [FAIL_W-1:0]  wr_fail;
    logic [TIME_W-1:0]  wr_qend;

    assign n       = active_slots(cfg.pool_size);
    assign rd_addr = (state_reg == ST_SCAN) ? scan_cnt_reg[IDX_W-1:0] : cur_reg.idx;
    assign rd_lat  = valid_reg[rd_addr] ? lat_avg_reg[rd_addr] : '0;
    assign rd_fail = valid_reg[rd_addr] ? fail_reg[rd_addr] : '0;
    assign rd_qend = valid_reg[rd_addr] ? qend_reg[rd_addr] : '0;

    // score = latency * (4 + 3 * failures), exact in fixed point
    assign eff_lat = (rd_lat == '0) ? DEFAULT_LAT : rd_lat;
    assign factor  = FACTOR_W'(4) + FACTOR_W'(3) * FACTOR_W'(rd_fail);

    // round((sample*256 + 4*old) / 5) = (2*sum + 5) / 10
    assign div_sum  = DIV_X_W'({cur_reg.sample, 8'h00}) + DIV_X_W'({rd_lat, 2'b00});
    assign div_x    = (div_sum << 1) + DIV_X_W'(5);
    assign div_prod = PROD_W'(div_x) * PROD_W'(RECIP10);

    assign fail_inc = (rd_fail == FAIL_MAX) ? FAIL_MAX : rd_fail + 1'b1;
    assign shift    = (fail_inc < MAX_SHIFT) ? fail_inc[SHIFT_W-1:0] : MAX_SHIFT[SHIFT_W-1:0];
    assign dur      = DUR_W'(cfg.ticks_per_second) << shift;

    // second scan stage: running minimum of score over unquarantined slots and of quarantine end
    assign fb_take   = s1_valid_reg && (!fb_any_reg || (s1_qend_reg < fb_qend_reg));
    assign best_take = s1_valid_reg && !s1_quar_reg
                       && (!found_reg || (s1_score_reg < low_score_reg));
    assign out_free  = !m_valid_reg || m_ready;

    assign q_pop   = (state_reg == ST_IDLE) && !q_status.empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        time_next       = time_reg;
        scan_cnt_next   = scan_cnt_reg;
        s1_valid_next   = 1'b0;
        s1_idx_next     = s1_idx_reg;
        s1_quar_next    = s1_quar_reg;
        s1_score_next   = s1_score_reg;
        s1_qend_next    = s1_qend_reg;
        found_next      = found_reg;
        low_score_next  = low_score_reg;
        best_idx_next   = best_idx_reg;
        fb_any_next     = fb_any_reg;
        fb_qend_next    = fb_qend_reg;
        fb_idx_next     = fb_idx_reg;
        res_empty_next  = res_empty_reg;
        new_lat_next    = new_lat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        wr_en           = 1'b0;
        wr_lat          = rd_lat;
        wr_fail         = rd_fail;
        wr_qend         = rd_qend;

        if (fb_take) begin
            fb_any_next  = 1'b1;
            fb_qend_next = s1_qend_reg;
            fb_idx_next  = s1_idx_reg;
        end
        if (best_take) begin
            found_next     = 1'b1;
            low_score_next = s1_score_reg;
            best_idx_next  = s1_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    cur_next = q_cmd;
                    unique case (q_cmd.op)
                        OP_SELECT: begin
                            found_next     = 1'b0;
                            fb_any_next    = 1'b0;
                            scan_cnt_next  = '0;
                            res_empty_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        OP_EMPTY: begin
                            res_empty_next = 1'b1;
                            state_next     = ST_RESULT;
                        end
                        OP_SUCCESS: state_next = ST_SUCC;
                        OP_FAILURE: state_next = ST_FAIL;
                        default:    time_next  = time_reg + 1'b1;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg < n) begin
                    s1_valid_next = 1'b1;
                    s1_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    s1_quar_next  = (rd_qend > time_reg);
                    s1_score_next = SCORE_W'(eff_lat) * SCORE_W'(factor);
                    s1_qend_next  = rd_qend;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else if (!s1_valid_reg) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SUCC: begin
                new_lat_next = (rd_lat == '0) ? LAT_W'({cur_reg.sample, 8'h00})
                                              : div_prod[RECIP_SHIFT +: LAT_W];
                state_next   = ST_SUCC_WR;
            end
            ST_SUCC_WR: begin
                wr_en      = 1'b1;
                wr_lat     = new_lat_reg;
                wr_fail    = '0;
                wr_qend    = '0;
                state_next = ST_IDLE;
            end
            ST_FAIL: begin
                wr_en      = 1'b1;
                wr_fail    = fail_inc;
                wr_qend    = time_reg + TIME_W'(dur);
                state_next = ST_IDLE;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.pool_empty  = res_empty_reg;
                    m_data_next.chosen_index = res_empty_reg ? '0
                                             : (found_reg ? best_idx_reg : fb_idx_reg);
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            time_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            valid_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            time_reg     <= time_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (wr_en) begin
                valid_reg[cur_reg.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        scan_cnt_reg   <= scan_cnt_next;
        s1_idx_reg     <= s1_idx_next;
        s1_quar_reg    <= s1_quar_next;
        s1_score_reg   <= s1_score_next;
        s1_qend_reg    <= s1_qend_next;
        found_reg      <= found_next;
        low_score_reg  <= low_score_next;
        best_idx_reg   <= best_idx_next;
        fb_any_reg     <= fb_any_next;
        fb_qend_reg    <= fb_qend_next;
        fb_idx_reg     <= fb_idx_next;
        res_empty_reg  <= res_empty_next;
        new_lat_reg    <= new_lat_next;
        m_data_reg     <= m_data_next;
        if (wr_en) begin
            lat_avg_reg[cur_reg.idx] <= wr_lat;
            fail_reg[cur_reg.idx]    <= wr_fail;
            qend_reg[cur_reg.idx]    <= wr_qend;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/endpoint_health_selector_core.sv
// Endpoint health selector top level.
//
// s_ channel (valid/ready) takes one item: action, endpoint_index, latency_ms.
// Select items return one transfer on the m_ channel (chosen_index,
// pool_empty); success, failure and tick items return nothing.
// cfg_wr_en/cfg_index/cfg_wdata write pool_size (index 0) and
// ticks_per_second (index 1); write only while the block is idle.
//
// Items pass through a two-entry command queue into a sequencer that owns
// the slot records. A select scans the slots one per cycle through a
// two-stage score pipeline. A success report first computes the new
// average and then writes the record, a failure report writes its record
// directly, and a tick only advances time in the idle state.
//
// Reset clears all slot records, time, the queue and the output register;
// pool_size returns to 0 and ticks_per_second to 1000.
// When the receiver stalls, the result holds in the output register, the
// sequencer waits on the next select, and s_ready drops once the queue fills.
`default_nettype none
module endpoint_health_selector_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  ehs_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output ehs_pkg::out_item_t               m_data,
    input  wire                              cfg_wr_en,
    input  wire [ehs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [ehs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ehs_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    queue_status_t q_status;
    logic          q_push, q_pop;
    cmd_t          q_push_cmd, q_pop_cmd;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POOL_SIZE:        cfg_next.pool_size        = cfg_wdata[POOL_W-1:0];
                CFG_TICKS_PER_SECOND: cfg_next.ticks_per_second = cfg_wdata[TPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pool_size        <= POOL_RESET;
            cfg_reg.ticks_per_second <= TPS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ehs_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    ehs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .status   (q_status)
    );

    ehs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_cmd    (q_pop_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/ehs_checker.sv
// port-level checker for the endpoint health selector and its bind
`default_nettype none
`include "endpoint_health_selector_core_defines.svh"
module ehs_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input ehs_pkg::out_item_t  m_data
);
    import ehs_pkg::*;

    // a stalled result stays put
    `EHS_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result moved")

    // an empty-pool answer never names a slot
    `EHS_ASSERT_IMP(a_empty, m_valid && m_data.pool_empty, m_data.chosen_index == '0, "index set")

    // reset drops the output register
    `EHS_ASSERT_NEXT_ALWAYS(a_rst_out, !aresetn, !m_valid, "m_valid high after reset")

    // the queue is empty right after reset, so input is open
    `EHS_ASSERT_NEXT_ALWAYS(a_rst_rdy, !aresetn, s_ready, "s_ready low after reset")

endmodule

bind endpoint_health_selector_core ehs_checker u_ehs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

FILE: verif/endpoint_health_selector_checker.sv
// scoreboard for the endpoint health selector: tracks slot health and checks every pick
module endpoint_health_selector_checker (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    input  wire                           s_ready,
    input  ehs_pkg::in_item_t             s_data,
    input  wire                           m_valid,
    input  wire                           m_ready,
    input  ehs_pkg::out_item_t            m_data,
    input  wire                           cfg_wr_en,
    input  wire [ehs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ehs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                            errors,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ehs_pkg::*;

    logic [LAT_W-1:0]  avg_q8   [MAX_ENDPOINTS];
    logic [FAIL_W-1:0] fail_cnt [MAX_ENDPOINTS];
    logic [TIME_W-1:0] quar_end [MAX_ENDPOINTS];
    logic [TIME_W-1:0] now_ticks;
    logic [POOL_W-1:0] pool_reg;
    logic [TPS_W-1:0]  tps_reg;
    out_item_t         expected_picks [$];
    out_item_t         want;

    task automatic apply_health_item(input in_item_t it);
        int          n;
        int          best;
        bit          found;
        int          shift;
        logic [63:0] lat;
        logic [63:0] score;
        logic [63:0] min_score;
        logic [63:0] sum;
        logic [63:0] dur;
        out_item_t   pick;
        n = (int'(pool_reg) > MAX_ENDPOINTS) ? MAX_ENDPOINTS : int'(pool_reg);
        case (it.action)
            ACT_SELECT: begin
                pick = '0;
                if (n == 0) begin
                    pick.pool_empty = 1'b1;
                end else begin
                    found = 1'b0;
                    best = 0;
                    min_score = '0;
                    for (int i = 0; i < n; i++) begin
                        // quarantined while the end lies strictly in the future
                        if (quar_end[i] <= now_ticks) begin
                            lat = (avg_q8[i] != '0) ? 64'(avg_q8[i]) : 64'(DEFAULT_LAT);
                            score = lat * (64'd4 + 64'd3 * 64'(fail_cnt[i]));
                            if (!found || score < min_score) begin
                                found = 1'b1;
                                min_score = score;
                                best = i;
                            end
                        end
                    end
                    if (!found) begin
                        best = 0;
                        for (int i = 1; i < n; i++) begin
                            if (quar_end[i] < quar_end[best]) begin
                                best = i;
                            end
                        end
                    end
                    pick.chosen_index = IDX_W'(best);
                end
                expected_picks = {expected_picks, pick};
            end
            ACT_TICK: begin
                now_ticks = now_ticks + 1'b1;
            end
            ACT_SUCCESS: begin
                if (int'(it.endpoint_index) < n) begin
                    if (avg_q8[it.endpoint_index] == '0) begin
                        avg_q8[it.endpoint_index] = LAT_W'({it.latency_ms, 8'h00});
                    end else begin
                        // 0.2 new + 0.8 old, rounded half up
                        sum = (64'(it.latency_ms) << 8) + 64'd4 * 64'(avg_q8[it.endpoint_index]);
                        avg_q8[it.endpoint_index] = LAT_W'((64'd2 * sum + 64'd5) / 64'd10);
                    end
                    fail_cnt[it.endpoint_index] = '0;
                    quar_end[it.endpoint_index] = '0;
                end
            end
            ACT_FAILURE: begin
                if (int'(it.endpoint_index) < n) begin
                    if (fail_cnt[it.endpoint_index] != FAIL_MAX) begin
                        fail_cnt[it.endpoint_index] = fail_cnt[it.endpoint_index] + 1'b1;
                    end
                    shift = (fail_cnt[it.endpoint_index] < MAX_SHIFT) ?
                            int'(fail_cnt[it.endpoint_index]) : int'(MAX_SHIFT);
                    dur = (64'd1 << shift) * 64'(tps_reg);
                    quar_end[it.endpoint_index] = now_ticks + TIME_W'(dur);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENDPOINTS; i++) begin
                avg_q8[i] = '0;
                fail_cnt[i] = '0;
                quar_end[i] = '0;
            end
            now_ticks = '0;
            pool_reg = POOL_RESET;
            tps_reg = TPS_RESET;
            expected_picks.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: unexpected result, got chosen_index %0d pool_empty %0d",
                             $time, m_data.chosen_index, m_data.pool_empty);
                    errors++;
                end else begin
                    want = expected_picks.pop_front();
                    if (m_data.chosen_index !== want.chosen_index) begin
                        $display("%0t: chosen_index expected %0d, got %0d",
                                 $time, want.chosen_index, m_data.chosen_index);
                        errors++;
                    end
                    if (m_data.pool_empty !== want.pool_empty) begin
                        $display("%0t: pool_empty expected %0d, got %0d",
                                 $time, want.pool_empty, m_data.pool_empty);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_POOL_SIZE:        pool_reg = cfg_wdata[POOL_W-1:0];
                    CFG_TICKS_PER_SECOND: tps_reg = cfg_wdata[TPS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                apply_health_item(s_data);
            end
        end
        pending = expected_picks.size();
    end

endmodule

FILE: verif/tb_endpoint_health_selector_core.sv
// testbench top for the endpoint health selector: stimulus, idling and verdict
module tb_endpoint_health_selector_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ehs_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  no_idle = 1'b0;
    int                    errors;
    int                    pending;

    // random phases: pool size, ticks per second, item count, failure heavy, no idling
    int ph_pool  [7] = '{16, 4, 1, 8, 31, 0, 0};
    int ph_tps   [7] = '{1, 2, 0, 65535, 3, 1000, 0};
    int ph_items [7] = '{350, 300, 400, 250, 300, 50, 100};
    bit ph_heavy [7] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    bit ph_quiet [7] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    endpoint_health_selector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    endpoint_health_selector_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 21);
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [1:0] act, input int idx, input int lat);
        in_item_t it;
        it.action = act;
        it.endpoint_index = IDX_W'(idx);
        it.latency_ms = SAMPLE_W'(lat);
        while (!no_idle && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // reports and ticks give no result, so allow the queue and sequencer to drain
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int         pool;
        int         tps;
        int         pool_n;
        int         r;
        int         idx;
        int         lat;
        logic [1:0] act;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pool after reset, reports ignored
        send_item(ACT_SELECT, 0, 0);
        send_item(ACT_SUCCESS, 0, 50);
        send_item(ACT_FAILURE, 15, 0);
        send_item(ACT_TICK, 0, 0);
        wait_quiet();
        write_reg(CFG_POOL_SIZE, 16);
        write_reg(CFG_TICKS_PER_SECOND, 2);
        send_item(ACT_SELECT, 7, 65535);
        send_item(ACT_SUCCESS, 3, 0);
        send_item(ACT_SUCCESS, 5, 65535);
        send_item(ACT_SUCCESS, 2, 100);
        send_item(ACT_SUCCESS, 2, 200);
        send_item(ACT_SELECT, 0, 0);
        send_item(ACT_FAILURE, 2, 0);
        send_item(ACT_SELECT, 0, 0);
        send_item(ACT_SUCCESS, 15, 1);
        send_item(ACT_SELECT, 15, 0);
        send_item(ACT_TICK, 0, 0);
        wait_quiet();
        // pool above the slot count, zero quarantine length
        write_reg(CFG_POOL_SIZE, 31);
        write_reg(CFG_TICKS_PER_SECOND, 0);
        send_item(ACT_FAILURE, 15, 0);
        send_item(ACT_SELECT, 0, 0);
        wait_quiet();
        write_reg(CFG_POOL_SIZE, 2);
        write_reg(CFG_TICKS_PER_SECOND, 3);
        send_item(ACT_FAILURE, 0, 0);
        send_item(ACT_FAILURE, 1, 0);
        send_item(ACT_FAILURE, 1, 0);
        send_item(ACT_SELECT, 0, 0);
        send_item(ACT_SUCCESS, 9, 300);
        wait_quiet();
        write_reg(CFG_TICKS_PER_SECOND, 65535);
        send_item(ACT_FAILURE, 0, 0);
        send_item(ACT_SELECT, 0, 0);
        send_item(ACT_TICK, 0, 0);

        for (int ph = 0; ph < 7; ph++) begin
            wait_quiet();
            if (ph == 6) begin
                pool = $urandom_range(1, 16);
                tps = $urandom_range(1, 8);
            end else begin
                pool = ph_pool[ph];
                tps = ph_tps[ph];
            end
            write_reg(CFG_POOL_SIZE, pool);
            write_reg(CFG_TICKS_PER_SECOND, tps);
            no_idle <= ph_quiet[ph];
            pool_n = (pool > MAX_ENDPOINTS) ? MAX_ENDPOINTS : pool;
            for (int k = 0; k < ph_items[ph]; k++) begin
                r = $urandom_range(99);
                // failure heavy phase drives the failure count into saturation
                if (ph_heavy[ph]) begin
                    act = (r < 20) ? ACT_SELECT : (r < 95) ? ACT_FAILURE : ACT_TICK;
                end else begin
                    act = (r < 35) ? ACT_SELECT : (r < 60) ? ACT_SUCCESS :
                          (r < 80) ? ACT_FAILURE : ACT_TICK;
                end
                if (pool_n > 0 && $urandom_range(9) != 0) begin
                    idx = $urandom_range(pool_n - 1);
                end else begin
                    idx = $urandom_range(15);
                end
                r = $urandom_range(9);
                if (r == 0) begin
                    lat = 0;
                end else if (r == 1) begin
                    lat = 65535;
                end else if (r < 6) begin
                    lat = $urandom_range(2000);
                end else begin
                    lat = $urandom_range(65535);
                end
                send_item(act, idx, lat);
            end
        end
        wait_quiet();

        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: endpoint_health_selector_core.f
+incdir+rtl/core
rtl/core/ehs_pkg.sv
rtl/core/ehs_queue.sv
rtl/core/ehs_front.sv
rtl/core/ehs_back.sv
rtl/core/endpoint_health_selector_core.sv
rtl/core/ehs_checker.sv
verif/endpoint_health_selector_checker.sv
verif/tb_endpoint_health_selector_core.sv
